// ===== hdl/rcs_pkg.sv =====
// rcs_pkg: widths, latencies and register codes of the column ray setup block
// shared by the channel interfaces, the delta distance pipeline and the top level
package rcs_pkg;

  localparam int MAP_BITS    = 8;
  localparam int FRAC_BITS   = 16;
  localparam int COLUMN_BITS = 12;

  localparam int POS_BITS   = MAP_BITS + FRAC_BITS;
  localparam int DIR_BITS   = FRAC_BITS + 4;
  localparam int RAY_BITS   = FRAC_BITS + 5;
  localparam int WIDTH_BITS = COLUMN_BITS + 1;

  localparam int CAMQ_BITS  = COLUMN_BITS + 1 + FRAC_BITS;
  localparam int CAM_BITS   = CAMQ_BITS + 1;
  localparam int PROD_BITS  = DIR_BITS + CAM_BITS;
  localparam int RSUM_BITS  = PROD_BITS - FRAC_BITS + 1;

  localparam int SQ_BITS    = 2 * RAY_BITS - 1;
  localparam int SUM_BITS   = SQ_BITS + 1;
  localparam int QUO_BITS   = 64;
  localparam int ROOT_BITS  = QUO_BITS / 2;
  localparam int DIST_BITS  = 32;
  localparam int HI_SHIFT   = QUO_BITS - 2 * FRAC_BITS;

  localparam int FRAC1_BITS = FRAC_BITS + 1;
  localparam int SIDE_BITS  = FRAC1_BITS + DIST_BITS;

  localparam int DELTA_LAT  = 1 + QUO_BITS + ROOT_BITS;
  localparam int FRONT_LAT  = CAMQ_BITS + 4;
  localparam int TOTAL_LAT  = FRONT_LAT + DELTA_LAT + 2;

  localparam int CFG_BITS   = POS_BITS;
  localparam int IDX_BITS   = 3;

  localparam logic [WIDTH_BITS-1:0] DEFAULT_WIDTH = WIDTH_BITS'(640);
  localparam logic [FRAC1_BITS-1:0] ONE_FX        = FRAC1_BITS'(1) << FRAC_BITS;
  localparam logic [CAM_BITS-1:0]   CAM_ONE       = CAM_BITS'(1) << FRAC_BITS;

  typedef enum logic [IDX_BITS-1:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y,
    REG_SCREEN_WIDTH
  } cfg_idx_e;

endpackage

// ===== hdl/rcs_col_if.sv =====
// rcs_col_if: column request channel, valid/ready with the column index
// depends on rcs_pkg
interface rcs_col_if;
  import rcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COLUMN_BITS-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);

endinterface

// ===== hdl/rcs_ray_if.sv =====
// rcs_ray_if: ray setup result channel, valid/ready with all ray fields
// depends on rcs_pkg
interface rcs_ray_if;
  import rcs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MAP_BITS-1:0]        map_cell_x;
  logic [MAP_BITS-1:0]        map_cell_y;
  logic                       step_x_negative;
  logic                       step_y_negative;
  logic [DIST_BITS-1:0]       delta_dist_x;
  logic [DIST_BITS-1:0]       delta_dist_y;
  logic [DIST_BITS-1:0]       side_dist_x;
  logic [DIST_BITS-1:0]       side_dist_y;
  logic signed [RAY_BITS-1:0] ray_dir_x;
  logic signed [RAY_BITS-1:0] ray_dir_y;

  modport source (
    output valid, map_cell_x, map_cell_y, step_x_negative, step_y_negative,
    output delta_dist_x, delta_dist_y, side_dist_x, side_dist_y, ray_dir_x, ray_dir_y,
    input ready
  );
  modport sink (
    input valid, map_cell_x, map_cell_y, step_x_negative, step_y_negative,
    input delta_dist_x, delta_dist_y, side_dist_x, side_dist_y, ray_dir_x, ray_dir_y,
    output ready
  );

endinterface

// ===== hdl/rcs_delta.sv =====
// rcs_delta: pipelined floor(sqrt(sum * 2^(2F) / den)) with saturation
// restoring divider, one quotient bit per stage, then one root bit per stage; uses rcs_pkg
module rcs_delta (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rcs_pkg::SUM_BITS-1:0]  sum_i,
  input  logic [rcs_pkg::SQ_BITS-1:0]   den_i,
  output logic [rcs_pkg::DIST_BITS-1:0] delta_o
);
  import rcs_pkg::*;

  localparam int SR_BITS  = ROOT_BITS + 3;
  localparam int SAT_BITS = DELTA_LAT;

  logic [SQ_BITS-1:0]  init_rem_q, init_den_q;
  logic [QUO_BITS-1:0] init_nq_q;
  logic                init_sat_d;
  logic [SAT_BITS-1:0] sat_sh_q;

  logic [SQ_BITS-1:0]  div_rem_q [QUO_BITS];
  logic [SQ_BITS-1:0]  div_rem_d [QUO_BITS];
  logic [SQ_BITS-1:0]  div_den_q [QUO_BITS];
  logic [QUO_BITS-1:0] div_nq_q  [QUO_BITS];
  logic [QUO_BITS-1:0] div_nq_d  [QUO_BITS];

  logic [QUO_BITS-1:0]  sq_rad_q  [ROOT_BITS];
  logic [QUO_BITS-1:0]  sq_rad_d  [ROOT_BITS];
  logic [SR_BITS-1:0]   sq_rem_q  [ROOT_BITS];
  logic [SR_BITS-1:0]   sq_rem_d  [ROOT_BITS];
  logic [ROOT_BITS-1:0] sq_root_q [ROOT_BITS];
  logic [ROOT_BITS-1:0] sq_root_d [ROOT_BITS];

  assign init_sat_d = (SQ_BITS + HI_SHIFT)'(sum_i) >= {den_i, {HI_SHIFT{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      init_rem_q <= SQ_BITS'(sum_i >> HI_SHIFT);
      init_nq_q  <= QUO_BITS'({sum_i, {(2 * FRAC_BITS){1'b0}}});
      init_den_q <= den_i;
      sat_sh_q   <= {sat_sh_q[SAT_BITS-2:0], init_sat_d};
    end
  end

  // divider stages
  always_comb begin
    logic [SQ_BITS-1:0]  src_rem;
    logic [SQ_BITS-1:0]  src_den;
    logic [QUO_BITS-1:0] src_nq;
    logic [SQ_BITS:0]    trial;
    logic                ge;
    for (int k = 0; k < QUO_BITS; k++) begin
      if (k == 0) begin
        src_rem = init_rem_q;
        src_den = init_den_q;
        src_nq  = init_nq_q;
      end else begin
        src_rem = div_rem_q[k-1];
        src_den = div_den_q[k-1];
        src_nq  = div_nq_q[k-1];
      end
      trial        = {src_rem, src_nq[QUO_BITS-1]};
      ge           = trial >= {1'b0, src_den};
      div_rem_d[k] = ge ? SQ_BITS'(trial - {1'b0, src_den}) : SQ_BITS'(trial);
      div_nq_d[k]  = {src_nq[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUO_BITS; k++) begin
        div_rem_q[k] <= div_rem_d[k];
        div_nq_q[k]  <= div_nq_d[k];
        if (k == 0) begin
          div_den_q[k] <= init_den_q;
        end else begin
          div_den_q[k] <= div_den_q[k-1];
        end
      end
    end
  end

  // square root stages
  always_comb begin
    logic [QUO_BITS-1:0]  src_rad;
    logic [SR_BITS-1:0]   src_rem;
    logic [ROOT_BITS-1:0] src_root;
    logic [SR_BITS-1:0]   rem2;
    logic [SR_BITS-1:0]   trial;
    logic                 ge;
    for (int k = 0; k < ROOT_BITS; k++) begin
      if (k == 0) begin
        src_rad  = div_nq_q[QUO_BITS-1];
        src_rem  = '0;
        src_root = '0;
      end else begin
        src_rad  = sq_rad_q[k-1];
        src_rem  = sq_rem_q[k-1];
        src_root = sq_root_q[k-1];
      end
      rem2         = {src_rem[SR_BITS-3:0], src_rad[QUO_BITS-1:QUO_BITS-2]};
      trial        = SR_BITS'({src_root, 2'b01});
      ge           = rem2 >= trial;
      sq_rem_d[k]  = ge ? SR_BITS'(rem2 - trial) : rem2;
      sq_root_d[k] = {src_root[ROOT_BITS-2:0], ge};
      sq_rad_d[k]  = {src_rad[QUO_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
        sq_rad_q[k]  <= sq_rad_d[k];
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
      end
    end
  end

  assign delta_o = sat_sh_q[SAT_BITS-1] ? '1 : DIST_BITS'(sq_root_q[ROOT_BITS-1]);

endmodule

// ===== hdl/raycast_column_ray_setup.sv =====
// raycast_column_ray_setup: per-column ray setup for a grid raycaster
// depends on rcs_pkg, rcs_col_if, rcs_ray_if and rcs_delta
//
//   channel  dir  handshake         payload
//   col      in   valid/ready       column
//   ray      out  valid/ready       map cells, steps, delta/side distances, ray dir
//   cfg      in   cfg_we_i          cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; TOTAL_LAT
// register stages (132 at the package values)
// the stage count comes mostly from the camera divider (one quotient bit a stage), the 64-stage delta
// divider and the 32-stage square root
// all stages advance together; a stalled output freezes the whole pipeline
// reset clears valid bits and configuration, but the screen width resets to 640; no clearing pass
module raycast_column_ray_setup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcs_pkg::IDX_BITS-1:0] cfg_idx_i,
  input  logic [rcs_pkg::CFG_BITS-1:0] cfg_data_i,
  rcs_col_if.sink                      col,
  rcs_ray_if.source                    ray
);
  import rcs_pkg::*;

  localparam logic signed [RSUM_BITS-1:0] RAY_MAX =
    {{(RSUM_BITS - RAY_BITS + 1){1'b0}}, {(RAY_BITS - 1){1'b1}}};
  localparam logic signed [RSUM_BITS-1:0] RAY_MIN =
    {{(RSUM_BITS - RAY_BITS + 1){1'b1}}, {(RAY_BITS - 1){1'b0}}};

  function automatic logic signed [RAY_BITS-1:0] sat_ray(input logic signed [RSUM_BITS-1:0] v);
    if (v > RAY_MAX) begin
      return RAY_BITS'(RAY_MAX);
    end else if (v < RAY_MIN) begin
      return RAY_BITS'(RAY_MIN);
    end
    return RAY_BITS'(v);
  endfunction

  function automatic logic [DIST_BITS-1:0] sat_side(input logic [SIDE_BITS-1:0] p);
    if (p[SIDE_BITS-1]) begin
      return '1;
    end
    return p[FRAC_BITS+DIST_BITS-1:FRAC_BITS];
  endfunction

  // configuration
  logic [POS_BITS-1:0]        pos_x_q, pos_y_q;
  logic signed [DIR_BITS-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [WIDTH_BITS-1:0]      width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= '0;
      width_q   <= DEFAULT_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_X:        pos_x_q   <= cfg_data_i[POS_BITS-1:0];
        REG_POS_Y:        pos_y_q   <= cfg_data_i[POS_BITS-1:0];
        REG_DIR_X:        dir_x_q   <= cfg_data_i[DIR_BITS-1:0];
        REG_DIR_Y:        dir_y_q   <= cfg_data_i[DIR_BITS-1:0];
        REG_PLANE_X:      plane_x_q <= cfg_data_i[DIR_BITS-1:0];
        REG_PLANE_Y:      plane_y_q <= cfg_data_i[DIR_BITS-1:0];
        REG_SCREEN_WIDTH: width_q   <= cfg_data_i[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;

  assign en        = !vld_q[TOTAL_LAT-1] || ray.ready;
  assign col.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], col.valid};
    end
  end

  // camera coordinate divider
  logic [WIDTH_BITS-1:0] wdiv;
  logic [CAMQ_BITS-1:0]  cam_num;
  logic [WIDTH_BITS-1:0] cam_rem_q [CAMQ_BITS];
  logic [WIDTH_BITS-1:0] cam_rem_d [CAMQ_BITS];
  logic [CAMQ_BITS-1:0]  cam_nq_q  [CAMQ_BITS];
  logic [CAMQ_BITS-1:0]  cam_nq_d  [CAMQ_BITS];

  assign wdiv    = (width_q == '0) ? WIDTH_BITS'(1) : width_q;
  assign cam_num = {col.column, 1'b0, {FRAC_BITS{1'b0}}};

  always_comb begin
    logic [WIDTH_BITS-1:0] src_rem;
    logic [CAMQ_BITS-1:0]  src_nq;
    logic [WIDTH_BITS:0]   trial;
    logic                  ge;
    for (int k = 0; k < CAMQ_BITS; k++) begin
      if (k == 0) begin
        src_rem = '0;
        src_nq  = cam_num;
      end else begin
        src_rem = cam_rem_q[k-1];
        src_nq  = cam_nq_q[k-1];
      end
      trial        = {src_rem, src_nq[CAMQ_BITS-1]};
      ge           = trial >= {1'b0, wdiv};
      cam_rem_d[k] = ge ? WIDTH_BITS'(trial - {1'b0, wdiv}) : WIDTH_BITS'(trial);
      cam_nq_d[k]  = {src_nq[CAMQ_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < CAMQ_BITS; k++) begin
        cam_rem_q[k] <= cam_rem_d[k];
        cam_nq_q[k]  <= cam_nq_d[k];
      end
    end
  end

  // plane * cam, ray direction, squares, sum
  logic signed [CAM_BITS-1:0]  cam;
  logic signed [PROD_BITS-1:0] prod_x_q, prod_y_q;
  logic signed [RAY_BITS-1:0]  rx_q, ry_q, rx2_q, ry2_q, rx3_q, ry3_q;
  logic [RAY_BITS-1:0]         ax, ay;
  logic [SQ_BITS-1:0]          axsq_q, aysq_q, dx_q, dy_q;
  logic [SUM_BITS-1:0]         ssum_q;

  assign cam = CAM_BITS'(cam_nq_q[CAMQ_BITS-1]) - CAM_ONE;
  assign ax  = rx_q[RAY_BITS-1] ? RAY_BITS'(-rx_q) : rx_q;
  assign ay  = ry_q[RAY_BITS-1] ? RAY_BITS'(-ry_q) : ry_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= plane_x_q * cam;
      prod_y_q <= plane_y_q * cam;
      rx_q     <= sat_ray(RSUM_BITS'(dir_x_q) + RSUM_BITS'(prod_x_q >>> FRAC_BITS));
      ry_q     <= sat_ray(RSUM_BITS'(dir_y_q) + RSUM_BITS'(prod_y_q >>> FRAC_BITS));
      axsq_q   <= SQ_BITS'(ax) * SQ_BITS'(ax);
      aysq_q   <= SQ_BITS'(ay) * SQ_BITS'(ay);
      rx2_q    <= rx_q;
      ry2_q    <= ry_q;
      ssum_q   <= SUM_BITS'(axsq_q) + SUM_BITS'(aysq_q);
      dx_q     <= axsq_q;
      dy_q     <= aysq_q;
      rx3_q    <= rx2_q;
      ry3_q    <= ry2_q;
    end
  end

  // delta distances, ray direction travels alongside
  logic [DIST_BITS-1:0]       delta_x, delta_y;
  logic signed [RAY_BITS-1:0] rpx_q [DELTA_LAT];
  logic signed [RAY_BITS-1:0] rpy_q [DELTA_LAT];

  rcs_delta u_delta_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (ssum_q),
    .den_i   (dx_q),
    .delta_o (delta_x)
  );

  rcs_delta u_delta_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (ssum_q),
    .den_i   (dy_q),
    .delta_o (delta_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rpx_q[0] <= rx3_q;
      rpy_q[0] <= ry3_q;
      for (int k = 1; k < DELTA_LAT; k++) begin
        rpx_q[k] <= rpx_q[k-1];
        rpy_q[k] <= rpy_q[k-1];
      end
    end
  end

  // side distances
  logic signed [RAY_BITS-1:0] rxe, rye, srx_q, sry_q;
  logic [FRAC1_BITS-1:0]      fx, fy;
  logic [SIDE_BITS-1:0]       side_px_q, side_py_q;
  logic [DIST_BITS-1:0]       dl_x_q, dl_y_q;

  assign rxe = rpx_q[DELTA_LAT-1];
  assign rye = rpy_q[DELTA_LAT-1];
  assign fx  = rxe[RAY_BITS-1] ? {1'b0, pos_x_q[FRAC_BITS-1:0]}
                               : ONE_FX - {1'b0, pos_x_q[FRAC_BITS-1:0]};
  assign fy  = rye[RAY_BITS-1] ? {1'b0, pos_y_q[FRAC_BITS-1:0]}
                               : ONE_FX - {1'b0, pos_y_q[FRAC_BITS-1:0]};

  logic [DIST_BITS-1:0]       out_dx_q, out_dy_q, out_sx_q, out_sy_q;
  logic signed [RAY_BITS-1:0] out_rx_q, out_ry_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_px_q <= SIDE_BITS'(fx) * SIDE_BITS'(delta_x);
      side_py_q <= SIDE_BITS'(fy) * SIDE_BITS'(delta_y);
      dl_x_q    <= delta_x;
      dl_y_q    <= delta_y;
      srx_q     <= rxe;
      sry_q     <= rye;
      out_dx_q  <= dl_x_q;
      out_dy_q  <= dl_y_q;
      out_sx_q  <= (srx_q == '0) ? '1 : sat_side(side_px_q);
      out_sy_q  <= (sry_q == '0) ? '1 : sat_side(side_py_q);
      out_rx_q  <= srx_q;
      out_ry_q  <= sry_q;
    end
  end

  assign ray.valid           = vld_q[TOTAL_LAT-1];
  assign ray.map_cell_x      = pos_x_q[POS_BITS-1:FRAC_BITS];
  assign ray.map_cell_y      = pos_y_q[POS_BITS-1:FRAC_BITS];
  assign ray.step_x_negative = out_rx_q[RAY_BITS-1];
  assign ray.step_y_negative = out_ry_q[RAY_BITS-1];
  assign ray.delta_dist_x    = out_dx_q;
  assign ray.delta_dist_y    = out_dy_q;
  assign ray.side_dist_x     = out_sx_q;
  assign ray.side_dist_y     = out_sy_q;
  assign ray.ray_dir_x       = out_rx_q;
  assign ray.ray_dir_y       = out_ry_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col.valid && col.ready) |=> vld_q[0])
    else $error("accepted column did not enter the pipeline");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !col.ready |-> (ray.valid && !ray.ready))
    else $error("input stalled without a blocked output");

  a_zero_x_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ray.valid && ray.ray_dir_x == '0) |-> (ray.delta_dist_x == '1 && ray.side_dist_x == '1))
    else $error("zero x ray without saturated distances");

  a_zero_y_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ray.valid && ray.ray_dir_y == '0) |-> (ray.delta_dist_y == '1 && ray.side_dist_y == '1))
    else $error("zero y ray without saturated distances");

  a_side_le_delta : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray.valid |-> (ray.side_dist_x <= ray.delta_dist_x && ray.side_dist_y <= ray.delta_dist_y))
    else $error("side distance exceeds delta distance");
`endif

endmodule

// ===== tb/rcs_tb_if.sv =====
`timescale 1ns / 100ps
// channel interfaces are taken from the rtl (rcs_col_if, rcs_ray_if)
// this file holds the transaction record shared by the testbench; depends on rcs_pkg
package rcs_tb_pkg;
  import rcs_pkg::*;

  typedef struct packed {
    logic [MAP_BITS-1:0]        map_cell_x;
    logic [MAP_BITS-1:0]        map_cell_y;
    logic                       step_x_negative;
    logic                       step_y_negative;
    logic [DIST_BITS-1:0]       delta_dist_x;
    logic [DIST_BITS-1:0]       delta_dist_y;
    logic [DIST_BITS-1:0]       side_dist_x;
    logic [DIST_BITS-1:0]       side_dist_y;
    logic signed [RAY_BITS-1:0] ray_dir_x;
    logic signed [RAY_BITS-1:0] ray_dir_y;
  } ray_rec_t;
endpackage

// ===== tb/raycast_column_ray_setup_tb.sv =====
`timescale 1ns / 100ps
// testbench for raycast_column_ray_setup: directed and random columns under several
// camera setups, results checked against an in-bench fixed point ray setup predictor
// depends on rcs_pkg, rcs_tb_pkg, rcs_col_if, rcs_ray_if and the rtl
module raycast_column_ray_setup_tb;
  import rcs_pkg::*;
  import rcs_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  rcs_col_if col ();
  rcs_ray_if ray ();

  raycast_column_ray_setup dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .col(col), .ray(ray)
  );

  localparam longint DMAX = 64'hFFFF_FFFF;

  // camera model
  logic [POS_BITS-1:0]   cam_pos_x, cam_pos_y;
  logic [DIR_BITS-1:0]   cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  logic [WIDTH_BITS-1:0] cam_width;

  ray_rec_t expected_rays[$];
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;
  int n_errors, n_sent, n_got, n_cycles, n_sat;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > 2000000) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("** raycast_column_ray_setup: FAILED **");
      $finish;
    end
  end

  function automatic longint floor_div_fx(longint p);
    longint q;
    q = p / (64'sd1 << FRAC_BITS);
    if (p < 0 && (p % (64'sd1 << FRAC_BITS)) != 0) q--;
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned grid_delta(longint unsigned s, longint unsigned d);
    longint unsigned hi, r, q;
    if (d == 0) return DMAX;
    hi = s / d;
    r = s % d;
    if (hi >= (64'd1 << HI_SHIFT)) return DMAX;
    q = hi;
    for (int i = 0; i < 2 * FRAC_BITS; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    q = int_sqrt(q);
    return (q > DMAX) ? DMAX : q;
  endfunction

  function automatic longint unsigned first_line_dist(longint unsigned f, longint unsigned d,
                                                      bit zero);
    longint unsigned p;
    if (zero) return DMAX;
    p = (f * d) >> FRAC_BITS;
    return (p > DMAX) ? DMAX : p;
  endfunction

  function automatic ray_rec_t setup_column(logic [COLUMN_BITS-1:0] x);
    ray_rec_t r;
    longint w, cam, rx, ry, rmax, rmin;
    longint unsigned ax, ay, s, dx, dy, fx, fy;
    w = (cam_width == 0) ? 1 : cam_width;
    cam = ((longint'(x) * 2) << FRAC_BITS) / w - (64'sd1 << FRAC_BITS);
    rmax = (64'sd1 << (RAY_BITS - 1)) - 1;
    rmin = -(64'sd1 << (RAY_BITS - 1));
    rx = longint'($signed(cam_dir_x)) + floor_div_fx(longint'($signed(cam_plane_x)) * cam);
    ry = longint'($signed(cam_dir_y)) + floor_div_fx(longint'($signed(cam_plane_y)) * cam);
    if (rx > rmax) rx = rmax;
    if (rx < rmin) rx = rmin;
    if (ry > rmax) ry = rmax;
    if (ry < rmin) ry = rmin;
    ax = (rx < 0) ? -rx : rx;
    ay = (ry < 0) ? -ry : ry;
    s = ax * ax + ay * ay;
    dx = grid_delta(s, ax * ax);
    dy = grid_delta(s, ay * ay);
    fx = 64'(cam_pos_x[FRAC_BITS-1:0]);
    fy = 64'(cam_pos_y[FRAC_BITS-1:0]);
    if (rx >= 0) fx = (64'd1 << FRAC_BITS) - fx;
    if (ry >= 0) fy = (64'd1 << FRAC_BITS) - fy;
    r.map_cell_x = cam_pos_x[POS_BITS-1:FRAC_BITS];
    r.map_cell_y = cam_pos_y[POS_BITS-1:FRAC_BITS];
    r.step_x_negative = rx < 0;
    r.step_y_negative = ry < 0;
    r.delta_dist_x = DIST_BITS'(dx);
    r.delta_dist_y = DIST_BITS'(dy);
    r.side_dist_x = DIST_BITS'(first_line_dist(fx, dx, ax == 0));
    r.side_dist_y = DIST_BITS'(first_line_dist(fy, dy, ay == 0));
    r.ray_dir_x = rx[RAY_BITS-1:0];
    r.ray_dir_y = ry[RAY_BITS-1:0];
    return r;
  endfunction

  // write enable stays high across back to back writes; set_camera lowers it
  task automatic write_reg(cfg_idx_e idx, logic [CFG_BITS-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_POS_X:        cam_pos_x = val[POS_BITS-1:0];
      REG_POS_Y:        cam_pos_y = val[POS_BITS-1:0];
      REG_DIR_X:        cam_dir_x = val[DIR_BITS-1:0];
      REG_DIR_Y:        cam_dir_y = val[DIR_BITS-1:0];
      REG_PLANE_X:      cam_plane_x = val[DIR_BITS-1:0];
      REG_PLANE_Y:      cam_plane_y = val[DIR_BITS-1:0];
      REG_SCREEN_WIDTH: cam_width = val[WIDTH_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [23:0] px, logic [23:0] py, logic [19:0] dx, logic [19:0] dy,
                            logic [19:0] plx, logic [19:0] ply, logic [12:0] w);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_DIR_X, CFG_BITS'(dx));
    write_reg(REG_DIR_Y, CFG_BITS'(dy));
    write_reg(REG_PLANE_X, CFG_BITS'(plx));
    write_reg(REG_PLANE_Y, CFG_BITS'(ply));
    write_reg(REG_SCREEN_WIDTH, CFG_BITS'(w));
    cfg_we_i <= 0;
  endtask

  // valid stays high between back to back transactions; idling and drain lower it
  task automatic send_column(logic [COLUMN_BITS-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      col.valid <= 0;
      @(posedge clk_i);
    end
    col.valid <= 1;
    col.column <= x;
    @(posedge clk_i);
    while (!col.ready) @(posedge clk_i);
    expected_rays.push_back(setup_column(x));
    n_sent++;
  endtask

  // wait for results to drain before touching configuration
  task automatic drain();
    col.valid <= 0;
    while (expected_rays.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 10) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (recv_hold) ray.ready <= 0;
    else ray.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    ray_rec_t got, exp_r;
    if (rst_ni && ray.valid && ray.ready) begin
      got = '{ray.map_cell_x, ray.map_cell_y, ray.step_x_negative, ray.step_y_negative,
              ray.delta_dist_x, ray.delta_dist_y, ray.side_dist_x, ray.side_dist_y,
              ray.ray_dir_x, ray.ray_dir_y};
      n_got++;
      if (got.delta_dist_x == DMAX || got.delta_dist_y == DMAX) n_sat++;
      if (expected_rays.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction %p", got);
      end else begin
        exp_r = expected_rays.pop_front();
        if (got !== exp_r) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch at %0d: expected %p actual %p", n_got, exp_r,
                                       got);
        end
      end
    end
  end

  task automatic test_directed();
    // identity camera, column extremes, zero ray components, width 0 and beyond width
    set_camera(24'h03_8000, 24'h05_4000, 20'sh10000, 20'sh0, 20'sh0, 20'sh0A8F5, 13'd640);
    send_column(12'd0); send_column(12'd320); send_column(12'd639); send_column(12'd640);
    send_column(12'd4095);
    drain();
    set_camera(24'hFF_FFFF, 24'h0, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 13'd4096);
    send_column(12'd0); send_column(12'd2048); send_column(12'd4095); send_column(12'd1);
    drain();
    set_camera(24'h0, 24'hFF_FFFF, 20'sh0, 20'sh0, 20'sh0, 20'sh0, 13'd0);
    send_column(12'd0); send_column(12'd4095); send_column(12'd7);
    drain();
    set_camera(24'h12_0000, 24'h34_FFFF, 20'shF0000, 20'sh0, 20'sh0, 20'sh10000, 13'd1);
    send_column(12'd0); send_column(12'd1); send_column(12'd4095); send_column(12'd2);
    drain();
  endtask

  task automatic random_camera();
    set_camera(24'($urandom), 24'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
               20'($urandom),
               13'(($urandom_range(3) == 0) ? $urandom : $urandom_range(4096, 1)));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        drain();
        random_camera();
      end
      send_column(COLUMN_BITS'(($urandom_range(3) == 0) ? $urandom
                                                        : $urandom_range(cam_width)));
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int i = 0; i < 200; i++) send_column(COLUMN_BITS'($urandom));
    join
    drain();
  endtask

  initial begin
    col.valid = 0;
    col.column = '0;
    cam_pos_x = 0; cam_pos_y = 0; cam_dir_x = 0; cam_dir_y = 0;
    cam_plane_x = 0; cam_plane_y = 0; cam_width = DEFAULT_WIDTH;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_column(12'd100);
    drain();
    send_idle_pct = 30; recv_idle_pct = 57;
    test_directed();
    test_random(130);
    send_idle_pct = 57; recv_idle_pct = 30;
    test_random(130);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(130);
    $display("columns sent %0d, rays checked %0d, saturated deltas %0d", n_sent, n_got, n_sat);
    if (n_errors == 0 && expected_rays.size() == 0) begin
      $display("** raycast_column_ray_setup: PASSED **");
    end else begin
      $display("errors %0d, left over %0d", n_errors, expected_rays.size());
      $display("** raycast_column_ray_setup: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rcs_pkg.sv
hdl/rcs_col_if.sv
hdl/rcs_ray_if.sv
hdl/rcs_delta.sv
hdl/raycast_column_ray_setup.sv
tb/rcs_tb_if.sv
tb/raycast_column_ray_setup_tb.sv
